// ===== rtl/core/top_k_smallest_selector_top_macros.svh =====
// Assertion macros used by the selector's controller
`ifndef TOP_K_SMALLEST_SELECTOR_TOP_MACROS_SVH
`define TOP_K_SMALLEST_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, disabled in reset
`define TKS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on clk, disabled in reset
`define TKS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/tks_pkg.sv =====
// Package: sizes, op codes, FSM states and the cell command word of the selector
`default_nettype none
package tks_pkg;

  localparam int K_MAX = 64;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int IDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int OP_W  = 2;
  localparam int POS_W = 6;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_EMIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Command word broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;       // insert value into the sorted row
    logic                    grow;      // row grows by one (else largest is displaced)
    logic                    rot;       // rotate the first last_idx+1 cells by one
    logic [CNT_W-1:0]        cnt;       // number of held values
    logic [IDX_W-1:0]        last_idx;  // wrap point for rotation
    logic signed [VAL_W-1:0] v;         // value offered
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/tks_cell.sv =====
// One cell of the sorted insertion chain: holds one value, shifts up or down
`default_nettype none
module tks_cell (
  input  logic                             clk,
  input  logic [tks_pkg::IDX_W-1:0]        idx,
  input  tks_pkg::cell_cmd_t               cmd,
  input  logic                             lt_left,
  input  logic signed [tks_pkg::VAL_W-1:0] val_left,
  input  logic signed [tks_pkg::VAL_W-1:0] val_right,
  input  logic signed [tks_pkg::VAL_W-1:0] val_head,
  output logic                             lt,
  output logic signed [tks_pkg::VAL_W-1:0] val
);
  import tks_pkg::*;

  logic signed [VAL_W-1:0] val_next;
  logic                    in_range;
  logic                    at_end;
  logic                    cmp;

  // Decide whether the offered value goes at or below this cell
  assign cmp      = cmd.v < val;
  assign in_range = {1'b0, idx} < cmd.cnt;
  assign at_end   = {1'b0, idx} == cmd.cnt;
  assign lt       = (in_range & cmp) | (cmd.grow & at_end);

  // Take the neighbor's value, the new value, or hold
  always_comb begin
    val_next = val;
    if (cmd.ins) begin
      if (lt) begin
        val_next = lt_left ? val_left : cmd.v;
      end
    end else if (cmd.rot) begin
      val_next = (idx == cmd.last_idx) ? val_head : val_right;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tks_ctrl.sv =====
// Controller: limit register, held count, emit sequencer and result registers
`default_nettype none
`include "top_k_smallest_selector_top_macros.svh"
module tks_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tks_pkg::OP_W-1:0]         op,
  input  logic signed [tks_pkg::VAL_W-1:0] value,
  input  logic                             cfg_we,
  input  logic [tks_pkg::CNT_W-1:0]        cfg_wdata,
  input  logic signed [tks_pkg::VAL_W-1:0] val_head,
  output logic                             busy,
  output tks_pkg::cell_cmd_t               cmd,
  output logic                             result_strobe,
  output logic signed [tks_pkg::VAL_W-1:0] out_value,
  output logic [tks_pkg::POS_W-1:0]        position,
  output logic                             last,
  output logic                             empty_res
);
  import tks_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  k_limit;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  kk;
  logic [CNT_W-1:0]  n_emit;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  last_idx;
  logic              accept;
  logic              do_add;
  logic              do_emit;
  logic              do_clear;
  logic              rot;
  logic              pos_last;

  // Decode the accepted word
  assign accept   = start & ~busy;
  assign do_add   = accept & (op == OP_ADD);
  assign do_emit  = accept & (op == OP_EMIT);
  assign do_clear = accept & (op == OP_CLEAR);
  assign pos_last = pos == last_idx;

  // Clamp the limit into 1..K_MAX
  always_comb begin
    kk = k_limit;
    if (k_limit == '0) begin
      kk = CNT_W'(1);
    end else if (k_limit > CNT_W'(K_MAX)) begin
      kk = CNT_W'(K_MAX);
    end
  end

  assign n_emit = (count > kk) ? kk : count;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_emit && n_emit != '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pos_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy = 1'b0;
    rot  = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        rot  = 1'b0;
      end
      ST_EMIT: begin
        busy = 1'b1;
        rot  = 1'b1;
      end
      default: begin
        busy = 1'b0;
        rot  = 1'b0;
      end
    endcase
  end

  // Held count update
  always_comb begin
    count_next = count;
    if (do_clear) begin
      count_next = '0;
    end else if (do_emit) begin
      count_next = n_emit;
    end else if (do_add && count < kk) begin
      count_next = count + CNT_W'(1);
    end
  end

  // Broadcast command to the chain
  always_comb begin
    cmd.ins      = do_add;
    cmd.grow     = count < kk;
    cmd.rot      = rot;
    cmd.cnt      = count;
    cmd.last_idx = last_idx;
    cmd.v        = value;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      k_limit       <= CNT_W'(K_MAX);
      count         <= '0;
      pos           <= '0;
      last_idx      <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      result_strobe <= 1'b0;
      if (cfg_we) begin
        k_limit <= cfg_wdata;
      end
      if (do_emit) begin
        pos      <= '0;
        last_idx <= IDX_W'(n_emit - CNT_W'(1));
        if (n_emit == '0) begin
          result_strobe <= 1'b1;
        end
      end else if (rot) begin
        pos           <= pos + IDX_W'(1);
        result_strobe <= 1'b1;
      end
    end
  end

  // Result word registers
  always_ff @(posedge clk) begin
    if (do_emit && n_emit == '0) begin
      out_value <= '0;
      position  <= '0;
      last      <= 1'b1;
      empty_res <= 1'b1;
    end else if (rot) begin
      out_value <= val_head;
      position  <= POS_W'(pos);
      last      <= pos_last;
      empty_res <= 1'b0;
    end
  end

  `TKS_ASSERT_NEXT(a_emit_goes_busy, do_emit && n_emit != '0, busy, "emit did not start")
  `TKS_ASSERT_NOW(a_empty_is_single, result_strobe && empty_res, last && position == '0, "bad empty word")
  `TKS_ASSERT_NOW(a_no_insert_in_emit, busy, !cmd.ins, "insert during emit")
  `TKS_ASSERT_NOW(a_count_capped, 1'b1, count <= CNT_W'(K_MAX), "held count overflow")

endmodule
`default_nettype wire

// ===== rtl/core/top_k_smallest_selector_top.sv =====
// Top level: k-smallest selector built from a chain of sorting cells
//
// Keeps the k smallest signed values offered since the last clear, sorted in
// a chain of K_MAX cells. A word is taken when start is high and busy is low.
//   op add:   the value is compared in every cell at once and the row shifts
//             up by one from its slot. A new add may follow at once.
//   op clear: the held count drops to zero.
//   op emit:  the chain rotates its held part one cell a cycle and the head
//             cell is sent out, so n values (held count capped at the limit)
//             come out as n registered words, ascending, with busy high while
//             the chain rotates and last set on the final one. The set is
//             back in place afterwards.
//             With nothing held, one word flagged empty_res comes in the
//             cycle after acceptance and busy stays low.
// Results are shown for one cycle with result_strobe high; the receiver
// cannot stall them. cfg_we writes k_limit (0 acts as 1, above K_MAX as K_MAX).
// Reset empties the set and sets k_limit to K_MAX; cell contents are not
// cleared, as only held entries are ever read.
`default_nettype none
module top_k_smallest_selector_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [tks_pkg::OP_W-1:0]         op,
  input  logic signed [tks_pkg::VAL_W-1:0] value,
  input  logic                             cfg_we,
  input  logic [tks_pkg::CNT_W-1:0]        cfg_wdata,
  output logic                             result_strobe,
  output logic signed [tks_pkg::VAL_W-1:0] out_value,
  output logic [tks_pkg::POS_W-1:0]        position,
  output logic                             last,
  output logic                             empty_res
);
  import tks_pkg::*;

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] vals [K_MAX];
  logic                    lts  [K_MAX];

  tks_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .value         (value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .val_head      (vals[0]),
    .busy          (busy),
    .cmd           (cmd),
    .result_strobe (result_strobe),
    .out_value     (out_value),
    .position      (position),
    .last          (last),
    .empty_res     (empty_res)
  );

  // Chain of cells; the tail wraps back to the head for rotation
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic                    lt_l;
    logic signed [VAL_W-1:0] val_l;
    logic signed [VAL_W-1:0] val_r;

    if (i == 0) begin : g_first
      assign lt_l  = 1'b0;
      assign val_l = '0;
    end else begin : g_inner
      assign lt_l  = lts[i-1];
      assign val_l = vals[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign val_r = vals[0];
    end else begin : g_body
      assign val_r = vals[i+1];
    end

    tks_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .cmd       (cmd),
      .lt_left   (lt_l),
      .val_left  (val_l),
      .val_right (val_r),
      .val_head  (vals[0]),
      .lt        (lts[i]),
      .val       (vals[i])
    );
  end

endmodule
`default_nettype wire
